// ----- sv/bmm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types, constants and helpers for the banded matrix multiply block.
// ----------------------------------------------------------------------------
package bmm_pkg;

	localparam int MAX_SIZE      = 256;
	localparam int MAX_BANDWIDTH = 8;
	localparam int FRAC_BITS     = 16;

	localparam int LDIM        = 2 * MAX_BANDWIDTH + 1;
	localparam int STORE_DEPTH = MAX_SIZE * LDIM;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int IDX_W       = 8;
	localparam int SIZE_W      = 9;
	localparam int BW_W        = 4;
	localparam int VAL_W       = 32;
	localparam int ACC_W       = 2 * VAL_W + $clog2(LDIM) + 1;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 9;

	typedef enum logic [1:0] {
		MODE_WRITE_A = 2'd0,
		MODE_WRITE_B = 2'd1,
		MODE_QUERY   = 2'd2,
		MODE_NONE    = 2'd3
	} bmm_mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_SAT   = 2'd2
	} bmm_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIZE   = 3'd0,
		CFG_A_LOW  = 3'd1,
		CFG_A_UP   = 3'd2,
		CFG_B_LOW  = 3'd3,
		CFG_B_UP   = 3'd4
	} bmm_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_DRAIN
	} bmm_state_t;

	typedef struct packed {
		logic [1:0]              mode;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] entry_value;
	} bmm_in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] product_value;
		logic [1:0]              status;
	} bmm_out_t;

	// band store address of entry (r,c), with c within the widest band of row r
	function automatic logic [ADDR_W-1:0] bmm_slot(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		return ADDR_W'(int'(r) * (LDIM - 1) + int'(c) + MAX_BANDWIDTH);
	endfunction

endpackage

// ----- sv/bmm_band_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_band_ram
// Single write port, single registered read port band store.
// ----------------------------------------------------------------------------
module bmm_band_ram #(
	parameter int DEPTH = 4352,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/bmm_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_mac
// Shared multiply-accumulate unit with Q16.16 truncation and saturation.
// ----------------------------------------------------------------------------
module bmm_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clr,
	input  logic                              en,
	input  logic signed [bmm_pkg::VAL_W-1:0]  a,
	input  logic signed [bmm_pkg::VAL_W-1:0]  b,
	output logic signed [bmm_pkg::VAL_W-1:0]  sum_value,
	output logic                              sat
);
	import bmm_pkg::*;

	logic signed [2*VAL_W-1:0] prod_s2;
	logic                      en_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   shifted;
	logic                      fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s2 <= 1'b0;
		end else begin
			en_s2 <= en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
		if (clr) begin
			acc_q <= '0;
		end else if (en_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_comb begin
		shifted = acc_q >>> FRAC_BITS;
		fits    = (shifted[ACC_W-1:VAL_W-1] == '0) || (shifted[ACC_W-1:VAL_W-1] == '1);
		sat     = !fits;
		if (fits) begin
			sum_value = shifted[VAL_W-1:0];
		end else if (shifted[ACC_W-1]) begin
			sum_value = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sum_value = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

endmodule

// ----- sv/banded_matrix_multiply_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banded_matrix_multiply_top
// Band stores for A and B, one multiply-accumulate unit and its sequencer.
// ----------------------------------------------------------------------------
// writes and rejected items: the check state sets the registered result strobe
// queries: check, then run for each k from k0 to k1, then drain, then the strobe;
//   the run feeds one product per cycle through the shared multiply-accumulate unit
// one transaction at a time; busy stays high until its result strobe
// after reset both stores are swept to zero, all 4352 entries, with busy high
// the receiver cannot stall: each result is shown for exactly one cycle
module banded_matrix_multiply_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  bmm_pkg::bmm_in_t                    item,
	output logic                                done,
	output bmm_pkg::bmm_out_t                   result,
	input  logic                                cfg_we,
	input  logic [bmm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bmm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bmm_pkg::*;

	bmm_state_t state_q, state_d;

	logic [SIZE_W-1:0] size_q;
	logic [BW_W-1:0]   a_low_q, a_up_q, b_low_q, b_up_q;

	bmm_in_t           item_q;
	logic [ADDR_W-1:0] clr_q, clr_d;
	logic [IDX_W-1:0]  k_q, k_d;
	logic [IDX_W-1:0]  k1_q, k1_d;
	logic [1:0]        drain_q, drain_d;
	logic              done_q, done_d;
	bmm_out_t          result_q, result_d;
	logic              term_s1;
	logic              term_d;

	logic [SIZE_W-1:0] n_eff;
	logic [SIZE_W-1:0] n_m1;
	logic [BW_W-1:0]   al, au, bl, bu;
	logic [SIZE_W:0]   pl, pu;
	logic [SIZE_W:0]   row_w, col_w, k_w;
	logic              in_size, wr_band, q_band;
	logic [SIZE_W:0]   k0_w, k1_w;

	logic              we_a, we_b, mac_clr;
	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic [VAL_W-1:0]  wdata, rdata_a, rdata_b;
	logic signed [VAL_W-1:0] sum_value;
	logic              sat;

	function automatic logic [BW_W-1:0] eff_bw(input logic [BW_W-1:0] r,
			input logic [SIZE_W-1:0] nm1);
		logic [BW_W-1:0] c;
		c = (r > BW_W'(MAX_BANDWIDTH)) ? BW_W'(MAX_BANDWIDTH) : r;
		return (SIZE_W'(c) > nm1) ? BW_W'(nm1) : c;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_W'(MAX_SIZE);
			a_low_q <= BW_W'(1);
			a_up_q  <= BW_W'(1);
			b_low_q <= BW_W'(1);
			b_up_q  <= BW_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIZE:  size_q  <= cfg_data[SIZE_W-1:0];
				CFG_A_LOW: a_low_q <= cfg_data[BW_W-1:0];
				CFG_A_UP:  a_up_q  <= cfg_data[BW_W-1:0];
				CFG_B_LOW: b_low_q <= cfg_data[BW_W-1:0];
				CFG_B_UP:  b_up_q  <= cfg_data[BW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (size_q == '0) begin
			n_eff = SIZE_W'(1);
		end else if (size_q > SIZE_W'(MAX_SIZE)) begin
			n_eff = SIZE_W'(MAX_SIZE);
		end else begin
			n_eff = size_q;
		end
		n_m1 = n_eff - SIZE_W'(1);
		al = eff_bw(a_low_q, n_m1);
		au = eff_bw(a_up_q, n_m1);
		bl = eff_bw(b_low_q, n_m1);
		bu = eff_bw(b_up_q, n_m1);
		pl = (SIZE_W+1)'(al) + (SIZE_W+1)'(bl);
		pu = (SIZE_W+1)'(au) + (SIZE_W+1)'(bu);
		if (pl > (SIZE_W+1)'(n_m1)) begin
			pl = (SIZE_W+1)'(n_m1);
		end
		if (pu > (SIZE_W+1)'(n_m1)) begin
			pu = (SIZE_W+1)'(n_m1);
		end

		row_w = (SIZE_W+1)'(item_q.row);
		col_w = (SIZE_W+1)'(item_q.col);
		k_w   = (SIZE_W+1)'(k_q);
		in_size = (row_w < (SIZE_W+1)'(n_eff)) && (col_w < (SIZE_W+1)'(n_eff));
		if (item_q.mode == MODE_WRITE_A) begin
			wr_band = (row_w <= col_w + (SIZE_W+1)'(al)) && (col_w <= row_w + (SIZE_W+1)'(au));
		end else begin
			wr_band = (row_w <= col_w + (SIZE_W+1)'(bl)) && (col_w <= row_w + (SIZE_W+1)'(bu));
		end
		q_band = (row_w <= col_w + pl) && (col_w <= row_w + pu);
		k0_w = (row_w > (SIZE_W+1)'(al)) ? row_w - (SIZE_W+1)'(al) : '0;
		k1_w = row_w + (SIZE_W+1)'(au);
		if (k1_w > (SIZE_W+1)'(n_m1)) begin
			k1_w = (SIZE_W+1)'(n_m1);
		end
		term_d = (k_w <= col_w + (SIZE_W+1)'(bl)) && (col_w <= k_w + (SIZE_W+1)'(bu));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			k_q     <= '0;
			k1_q    <= '0;
			drain_q <= '0;
			done_q  <= 1'b0;
			term_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			k_q     <= k_d;
			k1_q    <= k1_d;
			drain_q <= drain_d;
			done_q  <= done_d;
			term_s1 <= (state_q == ST_RUN) && term_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (start && !busy) begin
			item_q <= item;
		end
	end

	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		k_d      = k_q;
		k1_d     = k1_q;
		drain_d  = drain_q;
		done_d   = 1'b0;
		result_d = result_q;
		we_a     = 1'b0;
		we_b     = 1'b0;
		waddr    = bmm_slot(item_q.row, item_q.col);
		wdata    = item_q.entry_value;
		mac_clr  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we_a  = 1'b1;
				we_b  = 1'b1;
				waddr = clr_q;
				wdata = '0;
				clr_d = clr_q + ADDR_W'(1);
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				result_d.product_value = '0;
				result_d.status        = STAT_RANGE;
				mac_clr                = 1'b1;
				case (item_q.mode)
					MODE_WRITE_A, MODE_WRITE_B: begin
						done_d  = 1'b1;
						state_d = ST_IDLE;
						if (in_size && wr_band) begin
							we_a            = (item_q.mode == MODE_WRITE_A);
							we_b            = (item_q.mode == MODE_WRITE_B);
							result_d.status = STAT_OK;
						end
					end
					MODE_QUERY: begin
						if (in_size && q_band) begin
							k_d     = k0_w[IDX_W-1:0];
							k1_d    = k1_w[IDX_W-1:0];
							state_d = ST_RUN;
						end else begin
							done_d  = 1'b1;
							state_d = ST_IDLE;
						end
					end
					default: begin
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_RUN: begin
				if (k_q == k1_q) begin
					drain_d = '0;
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + IDX_W'(1);
				end
			end
			ST_DRAIN: begin
				drain_d = drain_q + 2'd1;
				if (drain_q == 2'd2) begin
					result_d.product_value = sum_value;
					result_d.status        = sat ? STAT_SAT : STAT_OK;
					done_d                 = 1'b1;
					state_d                = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign raddr_a = bmm_slot(item_q.row, k_q);
	assign raddr_b = bmm_slot(k_q, item_q.col);

	bmm_band_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (VAL_W)
	) u_a_store (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	bmm_band_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (VAL_W)
	) u_b_store (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	bmm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (mac_clr),
		.en        (term_s1),
		.a         (rdata_a),
		.b         (rdata_b),
		.sum_value (sum_value),
		.sat       (sat)
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_CHECK || state_q == ST_DRAIN))
		else $error("result strobe without a transaction in flight");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (k_q <= k1_q))
		else $error("product index ran past the band");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status == STAT_SAT) |->
		(result_q.product_value == {1'b1, {(VAL_W-1){1'b0}}} ||
		 result_q.product_value == {1'b0, {(VAL_W-1){1'b1}}}))
		else $error("saturated result not at a limit");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status == STAT_RANGE) |-> (result_q.product_value == '0))
		else $error("rejected transaction with non-zero value");

endmodule
